[rtl/sag_pkg.sv]
// ----------------------------------------------------------------------------
// sag_pkg
// Shared types and constants for the slot allocator with gap stack.
// ----------------------------------------------------------------------------
package sag_pkg;

  localparam int CAPACITY = 64;

  typedef enum logic [2:0] {
    ACT_ALLOC     = 3'd0,
    ACT_FETCH_CHG = 3'd1,
    ACT_FETCH_RD  = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_REFRESH   = 3'd4,
    ACT_CLEAR     = 3'd5,
    ACT_FREEZE    = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FROZEN   = 2'd2,
    ST_FULL     = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ADD    = 2'd1,
    EV_REMOVE = 2'd2,
    EV_CLEAR  = 2'd3
  } evt_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic [1:0] FLAG_DEAD  = 2'b01;
  localparam logic [1:0] FLAG_ALIEN = 2'b10;
  localparam logic [1:0] FLAG_NONE  = 2'b00;

  typedef struct packed {
    logic [5:0] slot;
    stat_t      status;
    evt_t       index_event;
    logic [6:0] used;
    logic       last;
  } word_t;

endpackage

[rtl/sag_ram.sv]
// ----------------------------------------------------------------------------
// sag_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sag_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sag_obuf.sv]
// ----------------------------------------------------------------------------
// sag_obuf
// Two-word result buffer; loads a whole step's words, drains one per handshake.
// ----------------------------------------------------------------------------
module sag_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [1:0]    load_cnt,
  input  sag_pkg::word_t load_w0,
  input  sag_pkg::word_t load_w1,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output sag_pkg::word_t out_word
);
  import sag_pkg::*;

  word_t      w0_r, w0_nxt;
  word_t      w1_r, w1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = w0_r;
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    w0_nxt  = w0_r;
    w1_nxt  = w1_r;
    cnt_nxt = cnt_r;
    if (load && can_load) begin
      w0_nxt  = load_w0;
      w1_nxt  = load_w1;
      cnt_nxt = load_cnt;
    end else if (pop) begin
      w0_nxt  = w1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
  end

endmodule

[rtl/slot_allocator_with_gap_stack.sv]
// ----------------------------------------------------------------------------
// slot_allocator_with_gap_stack
// Slot table with dead/alien flags in RAM and a RAM-based stack of freed gaps.
// The first result word becomes valid once execute loads the result buffer.
// A new request is taken only in idle: accept, then execute, whether the step
// yields one word or two; a stalled result port holds the request in execute.
// The commit write lands in the accept cycle, the action's RAM write in execute.
// Reset clears counters, pending and frozen state; RAMs are not cleared.
// ----------------------------------------------------------------------------
module slot_allocator_with_gap_stack (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [5:0] in_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_result_slot,
  output logic [1:0] out_status,
  output logic [1:0] out_index_event,
  output logic [6:0] out_used_count,
  output logic       out_last
);
  import sag_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 6) ? CW : 6;

  state_t       state_r, state_nxt;
  logic [2:0]   act_r, act_nxt;
  logic [5:0]   slot_r, slot_nxt;
  logic         cm_r, cm_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic         pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_slot_r, pend_slot_nxt;
  logic         frozen_r, frozen_nxt;

  logic          fl_we, fl_re;
  logic [SW-1:0] fl_waddr, fl_raddr;
  logic [1:0]    fl_wdata, fl_rdata;
  logic          gp_we, gp_re;
  logic [SW-1:0] gp_waddr, gp_raddr, gp_wdata, gp_rdata;

  logic          accept, commit_now, live;
  act_t          act_in, act;
  logic [SW-1:0] s_idx, g;
  logic          ld;
  logic [1:0]    ld_cnt;
  word_t         ld_w0, ld_w1, w_cm, w_act, ow;
  logic          can_load;
  logic          act_known;

  assign act_in   = act_t'(in_action);
  assign act      = act_t'(act_r);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign s_idx    = SW'(slot_r);
  assign live     = (EW'(slot_r) < EW'(count_r)) && ((fl_rdata & FLAG_DEAD) == FLAG_NONE);
  assign commit_now = accept && pend_v_r && (act_in inside
      {ACT_ALLOC, ACT_FETCH_CHG, ACT_FETCH_RD, ACT_REMOVE, ACT_REFRESH, ACT_FREEZE});
  assign act_known = act inside
      {ACT_ALLOC, ACT_FETCH_CHG, ACT_FETCH_RD, ACT_REMOVE, ACT_REFRESH, ACT_CLEAR, ACT_FREEZE};

  assign fl_re    = accept;
  assign fl_raddr = SW'(in_slot);
  assign gp_re    = accept;
  assign gp_raddr = SW'(depth_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    slot_nxt      = slot_r;
    cm_nxt        = cm_r;
    depth_nxt     = depth_r;
    count_nxt     = count_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    frozen_nxt    = frozen_r;
    fl_we         = 1'b0;
    fl_waddr      = pend_slot_r;
    fl_wdata      = FLAG_NONE;
    gp_we         = 1'b0;
    gp_waddr      = SW'(depth_r);
    gp_wdata      = s_idx;
    g             = gp_rdata;
    ld            = 1'b0;
    w_act         = '{slot: 6'd0, status: ST_OK, index_event: EV_NONE, used: 7'd0,
                      last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          slot_nxt  = in_slot;
          cm_nxt    = commit_now;
          state_nxt = S_EXEC;
          if (commit_now) begin
            fl_we      = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end
      end
      S_EXEC: begin
        if (can_load) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
          case (act)
            ACT_ALLOC: begin
              if (frozen_r) begin
                w_act.status = ST_FROZEN;
              end else if (depth_r != '0) begin
                depth_nxt  = depth_r - CW'(1);
                fl_we      = 1'b1;
                fl_waddr   = g;
                fl_wdata   = FLAG_ALIEN;
                pend_v_nxt = 1'b1;
                pend_slot_nxt = g;
                w_act.slot = 6'(g);
              end else if (count_r == CW'(CAPACITY)) begin
                w_act.status = ST_FULL;
              end else begin
                fl_we      = 1'b1;
                fl_waddr   = SW'(count_r);
                fl_wdata   = FLAG_ALIEN;
                count_nxt  = count_r + CW'(1);
                pend_v_nxt = 1'b1;
                pend_slot_nxt = SW'(count_r);
                w_act.slot = 6'(count_r);
              end
            end
            ACT_FETCH_CHG: begin
              w_act.slot = slot_r;
              if (frozen_r) begin
                w_act.status = ST_FROZEN;
              end else if (!live) begin
                w_act.status = ST_NOTFOUND;
              end else begin
                fl_we      = 1'b1;
                fl_waddr   = s_idx;
                fl_wdata   = fl_rdata | FLAG_ALIEN;
                pend_v_nxt = 1'b1;
                pend_slot_nxt = s_idx;
                w_act.index_event = EV_REMOVE;
              end
            end
            ACT_FETCH_RD: begin
              w_act.slot   = slot_r;
              w_act.status = live ? ST_OK : ST_NOTFOUND;
            end
            ACT_REMOVE: begin
              w_act.slot = slot_r;
              if (frozen_r) begin
                w_act.status = ST_FROZEN;
              end else if (!live) begin
                w_act.status = ST_NOTFOUND;
              end else begin
                fl_we    = 1'b1;
                fl_waddr = s_idx;
                fl_wdata = FLAG_ALIEN | FLAG_DEAD;
                if (depth_r < CW'(CAPACITY)) begin
                  gp_we     = 1'b1;
                  depth_nxt = depth_r + CW'(1);
                end
                w_act.index_event = EV_REMOVE;
              end
            end
            ACT_CLEAR: begin
              if (frozen_r) begin
                w_act.status = ST_FROZEN;
              end else begin
                count_nxt  = '0;
                depth_nxt  = '0;
                pend_v_nxt = 1'b0;
                w_act.index_event = EV_CLEAR;
              end
            end
            ACT_FREEZE: begin
              frozen_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    w_act.used = 7'(count_nxt);
    w_cm = '{slot: 6'(pend_slot_r), status: ST_OK, index_event: EV_ADD,
             used: 7'(count_nxt), last: 1'b0};
    if (!act_known) begin
      ld_cnt = 2'd0;
      ld_w0  = w_act;
      ld_w1  = w_act;
    end else if (cm_r) begin
      ld_cnt = 2'd2;
      ld_w0  = w_cm;
      ld_w1  = w_act;
    end else begin
      ld_cnt = 2'd1;
      ld_w0  = w_act;
      ld_w1  = w_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cm_r        <= 1'b0;
      depth_r     <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      pend_slot_r <= '0;
      frozen_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cm_r        <= cm_nxt;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_slot_r <= pend_slot_nxt;
      frozen_r    <= frozen_nxt;
    end
    act_r  <= act_nxt;
    slot_r <= slot_nxt;
  end

  sag_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_flag_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .re    (fl_re),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  sag_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_gap_ram (
    .clk   (clk),
    .we    (gp_we),
    .waddr (gp_waddr),
    .wdata (gp_wdata),
    .re    (gp_re),
    .raddr (gp_raddr),
    .rdata (gp_rdata)
  );

  sag_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ld),
    .load_cnt  (ld_cnt),
    .load_w0   (ld_w0),
    .load_w1   (ld_w1),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (ow)
  );

  assign out_result_slot = ow.slot;
  assign out_status      = ow.status;
  assign out_index_event = ow.index_event;
  assign out_used_count  = ow.used;
  assign out_last        = ow.last;

endmodule
